// ===== rtl/core/half_single_float_converter_defines.svh =====
// assertion macros for the half/single converter
// no dependencies; included by the top level
`ifndef HALF_SINGLE_FLOAT_CONVERTER_DEFINES_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_DEFINES_SVH

// property that holds whenever reset is low
`define HSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define HSFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/hsfc_pkg.sv =====
// shared types, codes and conversion functions for the half/single converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hsfc_pkg;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] value_in;
  } hsfc_in_t;

  typedef struct packed {
    logic [31:0] value_out;
  } hsfc_out_t;

  localparam logic [31:0] S_INF      = 32'h7F800000;
  localparam logic [31:0] S_QUIET    = 32'h00400000;
  localparam logic [30:0] S_OVF_MAG  = 31'h477FF000;
  localparam logic [15:0] H_INF      = 16'h7C00;
  localparam logic [15:0] H_NAN      = 16'h7E00;

  // half to single, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [22:0] frac;
    logic [31:0] r;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    frac = 23'({m, 13'd0} << (4'd10 - p));
    if (e == 5'h1F) begin
      r = (m == 10'd0) ? S_INF : (S_INF | S_QUIET | {9'd0, m, 13'd0});
    end else if (e != 5'd0) begin
      r = {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end else if (m == 10'd0) begin
      r = 32'd0;
    end else begin
      r = {1'b0, 8'({4'd0, p} + 8'd103), frac};
    end
    r[31] = s;
    return r;
  endfunction

  // single to half, round to nearest even
  function automatic logic [15:0] single_to_half(input logic [31:0] w);
    logic        s;
    logic [30:0] mag;
    logic [7:0]  e;
    logic [22:0] m;
    logic [14:0] r;
    logic [12:0] rem;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] low;
    logic [23:0] half;
    logic [15:0] o;
    s   = w[31];
    mag = w[30:0];
    e   = mag[30:23];
    m   = mag[22:0];
    r   = 15'({e[4:0] - 5'd16, m[22:13]});
    rem = m[12:0];
    sig = {1'b1, m};
    sh  = 5'(8'd126 - e);
    q   = sig >> sh;
    low = sig & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 5'd1);
    if (mag > S_INF[30:0]) begin
      o = H_NAN;
    end else if (mag >= S_OVF_MAG) begin
      o = H_INF;
    end else if (e >= 8'd113) begin
      if (rem > 13'h1000 || (rem == 13'h1000 && r[0])) r = r + 15'd1;
      o = {1'b0, r};
    end else if (e < 8'd102) begin
      o = 16'd0;
    end else begin
      if (low > half || (low == half && q[0])) q = q + 24'd1;
      o = {1'b0, q[14:0]};
    end
    o[15] = s;
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hsfc_stream_if.sv =====
// valid/ready channel carrying a payload of a given struct
// depends on hsfc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface hsfc_in_if;
  import hsfc_pkg::*;
  logic     valid;
  logic     ready;
  hsfc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsfc_out_if;
  import hsfc_pkg::*;
  logic      valid;
  logic      ready;
  hsfc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hsfc_convert.sv =====
// combinational conversion between the input and result registers
// depends on hsfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module hsfc_convert
  import hsfc_pkg::*;
(
  input  hsfc_in_t  item,
  output hsfc_out_t result
);
  // pick the direction
  always_comb begin
    case (item.operation)
      OP_H2S:  result.value_out = half_to_single(item.value_in[15:0]);
      OP_S2H:  result.value_out = {16'd0, single_to_half(item.value_in)};
      default: result.value_out = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/half_single_float_converter.sv =====
// top level: input register, conversion logic, result register
// depends on hsfc_pkg, hsfc_stream_if, hsfc_convert, defines header
//
// channel   dir   payload
// in        sink  operation, value_in
// out       src   value_out
//
// one item per cycle while out is not stalled; an accepted item is
// shown after the input and result registers, a two-stage pipeline
// rst clears both valid bits; payload registers are not reset
// a stall at out holds the result and back-pressures in only when full
`timescale 1ns / 1ps
`default_nettype none
`include "half_single_float_converter_defines.svh"
module half_single_float_converter
  import hsfc_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  hsfc_in_if.sink    in,
  hsfc_out_if.source out
);
  logic      in_vld;
  hsfc_in_t  in_reg;
  logic      out_vld;
  hsfc_out_t out_reg;
  hsfc_out_t conv;
  logic      adv;

  assign adv      = !out_vld || out.ready;
  assign in.ready = !in_vld || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in.ready) begin
      in_vld <= in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in.ready && in.valid) in_reg <= in.data;
  end

  hsfc_convert u_convert (.item(in_reg), .result(conv));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && in_vld) out_reg <= conv;
  end

  assign out.valid = out_vld;
  assign out.data  = out_reg;

  // checks
  `HSFC_ASSERT(a_full_stall, (in_vld && out_vld && !out.ready) |-> !in.ready, "in ready while full")
  `HSFC_ASSERT(a_move, (in_vld && adv) |=> out_vld, "pipeline item lost")
  `HSFC_ASSERT(a_s2h_upper, (out_vld && $past(adv && in_vld && in_reg.operation == OP_S2H)) |-> (out_reg.value_out[31:16] == 16'd0), "half result upper bits set")
  `HSFC_ASSERT_ALWAYS(a_reset, $past(rst) |-> (!in_vld && !out_vld), "valid after reset")
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking bench for the half/single float converter
// depends on hsfc_pkg, hsfc_stream_if and the converter top level
`timescale 1ns / 1ps
module testbench;
  import hsfc_pkg::*;

  logic clk;
  logic rst;
  logic src_idle_on;
  logic snk_idle_on;
  int   errors;
  int   quiet_cycles;
  logic [31:0] pending_results[$];

  hsfc_in_if  in_ch();
  hsfc_out_if out_ch();

  half_single_float_converter u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // expected half to single widening
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    int          lead;
    sgn = {h[15], 31'd0};
    ex  = h[14:10];
    man = h[9:0];
    if (ex == 5'h1F) begin
      if (man == 10'd0) return sgn | 32'h7F800000;
      return sgn | 32'h7FC00000 | {9'd0, man, 13'd0};
    end
    if (ex != 5'd0) return sgn | ({24'd0, 3'd0, ex} + 32'd112) << 23 | {9'd0, man, 13'd0};
    if (man == 10'd0) return sgn;
    lead = 9;
    while (man[lead] == 1'b0) lead--;
    return sgn | (32'(lead + 103) << 23) | ((32'(man) << (23 - lead)) & 32'h7FFFFF);
  endfunction

  // expected single to half narrowing, round to nearest even
  function automatic logic [31:0] narrow_single(input logic [31:0] w);
    logic [31:0] sgn;
    logic [31:0] mag;
    logic [31:0] ex;
    logic [31:0] man;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] sig;
    logic [31:0] sh;
    logic [31:0] halfway;
    sgn = {16'd0, w[31], 15'd0};
    mag = {1'b0, w[30:0]};
    ex  = mag >> 23;
    man = mag & 32'h7FFFFF;
    if (mag > 32'h7F800000) return sgn | 32'h7E00;
    if (mag >= 32'h477FF000) return sgn | 32'h7C00;
    if (ex >= 113) begin
      res = ((ex - 112) << 10) | (man >> 13);
      rem = man & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && res[0])) res++;
      return sgn | res;
    end
    if (ex < 102) return sgn;
    sig = man | 32'h800000;
    sh  = 126 - ex;
    res = sig >> sh;
    rem = sig & ((32'd1 << sh) - 1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && res[0])) res++;
    return sgn | res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h", what, got, want);
    errors++;
  endtask

  // drive one item and wait for acceptance; valid stays high for a following item
  task automatic send_item(input op_t op, input logic [31:0] v);
    while (src_idle_on && ($urandom_range(99) < 14)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{operation: op, value_in: v};
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(op == OP_H2S ? widen_half(v[15:0]) : narrow_single(v));
  endtask

  // sink readiness
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(snk_idle_on && ($urandom_range(99) < 14));
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("FAILURE");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected", out_ch.data.value_out, 32'd0);
        end else begin
          if (out_ch.data.value_out !== pending_results[0])
            report_mismatch("value_out", out_ch.data.value_out, pending_results[0]);
          void'(pending_results.pop_front());
        end
      end
    end
  end

  task automatic test_directed_half();
    logic [15:0] pats[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h8200, 16'h03FF,
                              16'h0400, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01,
                              16'hFFFF, 16'h3C00};
    foreach (pats[i]) send_item(OP_H2S, {16'hFFFF, pats[i]});
  endtask

  task automatic test_directed_single();
    logic [31:0] pats[13] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800001,
                              32'h7FFFFFFF, 32'h477FF000, 32'h477FEFFF, 32'h33000000,
                              32'h33000001, 32'h387FE000, 32'h3F801000, 32'h3F803000,
                              32'h00000001};
    foreach (pats[i]) send_item(OP_S2H, pats[i]);
  endtask

  task automatic test_random();
    logic [31:0] v;
    for (int n = 0; n < 1950; n++) begin
      src_idle_on = (n < 700 || n > 1000);
      snk_idle_on = (n < 700 || n > 1000);
      v = $urandom();
      // bias half the items toward the half range
      if ($urandom_range(1) == 0) v[30:23] = 8'($urandom_range(142, 98));
      send_item(op_t'($urandom_range(1)), v);
    end
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_half();
    test_directed_single();
    test_random();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
